FILE: hdl/gasa_pkg.sv
// Shared types, codes and constants for the glyph atlas shelf allocator.
`timescale 1ns / 1ps

package gasa_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam logic [7:0] TEXEL_MAX = 8'd255;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_BLANK  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_RANGE     = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  s;
    logic [7:0]  t;
    logic [7:0]  layer;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [15:0] bx;
    logic [15:0] by;
  } entry_t;

  // Table write from the packer; the write always marks the code present.
  typedef struct packed {
    logic   en;
    entry_t entry;
  } tbl_wr_t;

  // Request held in the work stage, minus its table address.
  typedef struct packed {
    req_type_t   req_type;
    logic        in_range;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
  } pk_req_t;

  typedef struct packed {
    status_t    status;
    entry_t     entry;
    logic [7:0] current_layer;
  } pk_rsp_t;

endpackage

FILE: hdl/gasa_if.sv
// Request and response channel interfaces of the glyph atlas shelf allocator.
`timescale 1ns / 1ps

interface gasa_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [15:0]        char_code;
  logic [15:0]        rect_width;
  logic [15:0]        rect_height;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;

  modport source (
    output valid, req_type, char_code, rect_width, rect_height, offset_x, offset_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, rect_width, rect_height, offset_x, offset_y,
    output ready
  );
endinterface

interface gasa_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         tex_s;
  logic [7:0]         tex_t;
  logic [7:0]         tex_layer;
  logic [7:0]         out_width;
  logic [7:0]         out_height;
  logic signed [15:0] out_bearing_x;
  logic signed [15:0] out_bearing_y;
  logic [7:0]         current_layer;

  modport source (
    output valid, status, tex_s, tex_t, tex_layer, out_width, out_height,
           out_bearing_x, out_bearing_y, current_layer,
    input  ready
  );
  modport sink (
    input  valid, status, tex_s, tex_t, tex_layer, out_width, out_height,
           out_bearing_x, out_bearing_y, current_layer,
    output ready
  );
endinterface

FILE: hdl/gasa_table.sv
// Direct-mapped glyph table: present bits, entry memory, write forwarding and clear sweep.
`timescale 1ns / 1ps

module gasa_table #(
  parameter int TABLE_ENTRIES = gasa_pkg::TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic             rd_present,
  output gasa_pkg::entry_t rd_entry,
  input  gasa_pkg::tbl_wr_t wr,
  input  logic [AW-1:0]    wr_addr,
  input  logic             clear_start,
  output logic             sweeping
);

  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  logic             present_mem [TABLE_ENTRIES];
  gasa_pkg::entry_t entry_mem   [TABLE_ENTRIES];
  logic [AW-1:0]    sweep_cnt;
  logic             fwd;

  // A write in the same cycle as the read of the same code wins.
  assign fwd = wr.en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (sweeping) begin
      present_mem[sweep_cnt] <= 1'b0;
    end else if (wr.en) begin
      present_mem[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      entry_mem[wr_addr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_present <= fwd ? 1'b1 : present_mem[rd_addr];
      rd_entry   <= fwd ? wr.entry : entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_start) begin
      sweeping  <= 1'b1;
      sweep_cnt <= '0;
    end else if (sweeping) begin
      if (sweep_cnt == LAST) begin
        sweeping <= 1'b0;
      end else begin
        sweep_cnt <= sweep_cnt + AW'(1);
      end
    end
  end

endmodule

FILE: hdl/gasa_packer.sv
// Shelf packing cursor state and the per-request decision logic.
`timescale 1ns / 1ps

module gasa_packer (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  gasa_pkg::pk_req_t req,
  input  logic              present,
  input  gasa_pkg::entry_t  stored,
  input  logic [7:0]        layer_count,
  output gasa_pkg::pk_rsp_t rsp,
  output gasa_pkg::tbl_wr_t wr
);

  logic [7:0] cursor_x, cursor_x_next;
  logic [8:0] cursor_y, cursor_y_next;
  logic [7:0] row_height, row_height_next;
  logic [7:0] fill_layer, fill_layer_next;

  always_comb begin
    logic             too_large;
    logic [7:0]       w8, h8;
    logic [8:0]       x_sum;
    logic [9:0]       y_sum;
    logic [8:0]       layer_inc;
    logic             wrap, overflow, no_room;
    logic [7:0]       cx1, rh1;
    logic [8:0]       cy1;
    logic [7:0]       cx2, rh2, fl2;
    logic [8:0]       cy2;
    gasa_pkg::entry_t placed;

    w8        = req.rect_width[7:0];
    h8        = req.rect_height[7:0];
    too_large = (|req.rect_width[15:8]) || (|req.rect_height[15:8]);

    // Row wrap first; it sticks even when the insert then finds no room.
    x_sum = {1'b0, cursor_x} + {1'b0, w8};
    wrap  = x_sum > {1'b0, gasa_pkg::TEXEL_MAX};
    cx1   = wrap ? 8'd0 : cursor_x;
    cy1   = wrap ? (cursor_y + {1'b0, row_height}) : cursor_y;
    rh1   = wrap ? 8'd0 : row_height;

    y_sum     = {1'b0, cy1} + {2'b0, h8};
    overflow  = y_sum > {2'b0, gasa_pkg::TEXEL_MAX};
    layer_inc = {1'b0, fill_layer} + 9'd1;
    no_room   = layer_inc >= {1'b0, layer_count};

    cx2 = overflow ? 8'd0 : cx1;
    cy2 = overflow ? 9'd0 : cy1;
    rh2 = overflow ? 8'd0 : rh1;
    fl2 = overflow ? layer_inc[7:0] : fill_layer;

    placed.s     = cx2;
    placed.t     = cy2[7:0];
    placed.layer = fl2;
    placed.w     = w8;
    placed.h     = h8;
    placed.bx    = req.offset_x;
    placed.by    = req.offset_y;

    cursor_x_next   = cursor_x;
    cursor_y_next   = cursor_y;
    row_height_next = row_height;
    fill_layer_next = fill_layer;
    rsp.status      = gasa_pkg::ST_OK;
    rsp.entry       = '0;
    wr.en           = 1'b0;
    wr.entry        = '0;

    if (req.req_type == gasa_pkg::REQ_CLEAR) begin
      cursor_x_next   = 8'd0;
      cursor_y_next   = 9'd0;
      row_height_next = 8'd0;
      fill_layer_next = 8'd0;
    end else if (!req.in_range) begin
      rsp.status = gasa_pkg::ST_RANGE;
    end else begin
      case (req.req_type)
        gasa_pkg::REQ_LOOKUP: begin
          if (present) begin
            rsp.entry = stored;
          end else begin
            rsp.status = gasa_pkg::ST_NOT_FOUND;
          end
        end
        gasa_pkg::REQ_BLANK: begin
          wr.en = 1'b1;
        end
        gasa_pkg::REQ_INSERT: begin
          if (too_large) begin
            rsp.status = gasa_pkg::ST_TOO_LARGE;
          end else if (overflow && no_room) begin
            cursor_x_next   = cx1;
            cursor_y_next   = cy1;
            row_height_next = rh1;
            rsp.status      = gasa_pkg::ST_FULL;
          end else begin
            cursor_x_next   = cx2 + w8;
            cursor_y_next   = cy2;
            row_height_next = (h8 > rh2) ? h8 : rh2;
            fill_layer_next = fl2;
            // Duplicate still moves the cursor but keeps the old entry.
            if (present) begin
              rsp.status = gasa_pkg::ST_DUPLICATE;
            end else begin
              rsp.entry = placed;
              wr.en     = 1'b1;
              wr.entry  = placed;
            end
          end
        end
        default: begin
          rsp.status = gasa_pkg::ST_OK;
        end
      endcase
    end

    rsp.current_layer = fill_layer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= 8'd0;
      cursor_y   <= 9'd0;
      row_height <= 8'd0;
      fill_layer <= 8'd0;
    end else if (fire) begin
      cursor_x   <= cursor_x_next;
      cursor_y   <= cursor_y_next;
      row_height <= row_height_next;
      fill_layer <= fill_layer_next;
    end
  end

endmodule

FILE: hdl/glyph_atlas_shelf_allocator_core.sv
// Top level of the glyph atlas shelf allocator: handshake, work stage and result register.
`timescale 1ns / 1ps

// Packs glyph rectangles into 255x255 atlas layers row by row and keeps a
// direct-mapped table of placed glyphs indexed by character code. Every
// request (insert, blank insert, lookup, clear) returns exactly one result.
// A request is accepted when the work stage is empty or handing on its
// request: the table memory is read as the request is taken, the packing
// decision and table write happen as the work stage hands it on, and the
// result waits in an output register until taken. A clear, and also reset,
// starts a clearing pass over the table's present bits, one entry
// per cycle; no request is accepted during that pass, and none is accepted
// while a clear is in the work stage. layer_count is written through
// cfg_wr_en/cfg_wr_data and must only change while the block is idle.
module glyph_atlas_shelf_allocator_core #(
  parameter int TABLE_ENTRIES = gasa_pkg::TABLE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  gasa_req_if.sink   req,
  gasa_rsp_if.source rsp
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [16:0] CODE_LIMIT = 17'(TABLE_ENTRIES);

  logic [7:0]          layer_count;
  logic                in_fire;
  logic                in_range;
  logic [AW-1:0]       rd_addr;

  logic                s1_valid;
  logic [AW-1:0]       s1_addr;
  gasa_pkg::pk_req_t   s1_req;
  logic                s1_fire;
  logic                s1_clear;

  logic                rd_present;
  gasa_pkg::entry_t    rd_entry;
  gasa_pkg::tbl_wr_t   wr;
  gasa_pkg::tbl_wr_t   wr_gated;
  logic                sweeping;
  gasa_pkg::pk_rsp_t   pk_rsp;

  logic                out_valid;
  gasa_pkg::pk_rsp_t   out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= 8'd0;
    end else if (cfg_wr_en) begin
      layer_count <= cfg_wr_data;
    end
  end

  assign in_range = {1'b0, req.char_code} < CODE_LIMIT;
  assign rd_addr  = in_range ? req.char_code[AW-1:0] : '0;

  assign s1_clear = s1_req.req_type == gasa_pkg::REQ_CLEAR;
  assign s1_fire  = s1_valid && (!out_valid || rsp.ready);
  // Hold requests back while a clear is pending, the table is being swept or the work stage is stalled.
  assign req.ready = !sweeping && !(s1_valid && s1_clear) && (!s1_valid || s1_fire);
  assign in_fire   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr               <= rd_addr;
      s1_req.req_type       <= gasa_pkg::req_type_t'(req.req_type);
      s1_req.in_range       <= in_range;
      s1_req.rect_width     <= req.rect_width;
      s1_req.rect_height    <= req.rect_height;
      s1_req.offset_x       <= req.offset_x;
      s1_req.offset_y       <= req.offset_y;
    end
  end

  assign wr_gated.en    = wr.en && s1_fire;
  assign wr_gated.entry = wr.entry;

  gasa_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (in_fire),
    .rd_addr    (rd_addr),
    .rd_present (rd_present),
    .rd_entry   (rd_entry),
    .wr         (wr_gated),
    .wr_addr    (s1_addr),
    .clear_start(s1_fire && s1_clear),
    .sweeping   (sweeping)
  );

  gasa_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .req        (s1_req),
    .present    (rd_present),
    .stored     (rd_entry),
    .layer_count(layer_count),
    .rsp        (pk_rsp),
    .wr         (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_q <= pk_rsp;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_q.status;
  assign rsp.tex_s         = out_q.entry.s;
  assign rsp.tex_t         = out_q.entry.t;
  assign rsp.tex_layer     = out_q.entry.layer;
  assign rsp.out_width     = out_q.entry.w;
  assign rsp.out_height    = out_q.entry.h;
  assign rsp.out_bearing_x = out_q.entry.bx;
  assign rsp.out_bearing_y = out_q.entry.by;
  assign rsp.current_layer = out_q.current_layer;

`ifndef ASSERT_OFF
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !req.ready)
    else $error("request accepted during table clearing pass");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_clear) |=>
      (rsp.valid && rsp.status == gasa_pkg::ST_OK && rsp.current_layer == 8'd0 && sweeping))
    else $error("clear did not return ok on layer zero and start the sweep");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != gasa_pkg::ST_OK) |->
      (rsp.tex_s == 8'd0 && rsp.tex_t == 8'd0 && rsp.tex_layer == 8'd0 &&
       rsp.out_width == 8'd0 && rsp.out_height == 8'd0 &&
       rsp.out_bearing_x == 16'sd0 && rsp.out_bearing_y == 16'sd0))
    else $error("failed request returned nonzero entry fields");

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !wr_gated.en)
    else $error("table write during clearing pass");
`endif

endmodule

FILE: sim/glyph_atlas_shelf_allocator_core_tb.sv
// Self-checking testbench for the glyph atlas shelf allocator core.
`timescale 1ns / 1ps

module glyph_atlas_shelf_allocator_core_tb;

  localparam int TABLE_ENTRIES = gasa_pkg::TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_PRINTED   = 40;
  localparam logic [15:0] SIZE_MAX = {8'd0, gasa_pkg::TEXEL_MAX};

  typedef struct {
    gasa_pkg::req_type_t kind;
    logic [15:0]         code;
    logic [15:0]         width;
    logic [15:0]         height;
    logic signed [15:0]  bear_x;
    logic signed [15:0]  bear_y;
  } glyph_req_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  gasa_req_if req_ch ();
  gasa_rsp_if rsp_ch ();

  glyph_atlas_shelf_allocator_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  // Packing state mirrored from the block
  logic [7:0]       layer_count;
  logic [7:0]       cursor_x;
  logic [8:0]       cursor_y;
  logic [7:0]       row_height;
  logic [7:0]       fill_layer;
  bit               glyph_present[TABLE_ENTRIES];
  gasa_pkg::entry_t glyph_table[TABLE_ENTRIES];

  gasa_pkg::pk_rsp_t expected_q[$];

  int mismatch_count = 0;
  int results_checked = 0;
  int requests_sent = 0;
  int kind_count[4] = '{default: 0};
  int status_seen[8] = '{default: 0};
  int deepest_layer = 0;
  int cycle_count = 0;

  // Sender and receiver pacing
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_request = 0;
  int hold_left = 0;
  int sink_mode = 0;
  int mode_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic gasa_pkg::pk_rsp_t place_glyph(glyph_req_t r);
    gasa_pkg::pk_rsp_t res;
    gasa_pkg::entry_t  slot;
    bit                rejected;
    res = '0;
    res.status = gasa_pkg::ST_OK;
    rejected = 1'b0;
    if (r.kind == gasa_pkg::REQ_CLEAR) begin
      foreach (glyph_present[i]) glyph_present[i] = 1'b0;
      fill_layer = '0;
      cursor_x = '0;
      cursor_y = '0;
      row_height = '0;
    end else if (int'(r.code) >= TABLE_ENTRIES) begin
      res.status = gasa_pkg::ST_RANGE;
    end else if (r.kind == gasa_pkg::REQ_LOOKUP) begin
      if (glyph_present[r.code]) res.entry = glyph_table[r.code];
      else res.status = gasa_pkg::ST_NOT_FOUND;
    end else if (r.kind == gasa_pkg::REQ_BLANK) begin
      glyph_table[r.code] = '0;
      glyph_present[r.code] = 1'b1;
    end else if (r.width > SIZE_MAX || r.height > SIZE_MAX) begin
      res.status = gasa_pkg::ST_TOO_LARGE;
    end else begin
      // wrap the row first; it sticks even if the atlas turns out full
      if (({8'd0, cursor_x} + r.width) > SIZE_MAX) begin
        cursor_x = '0;
        cursor_y = cursor_y + {1'b0, row_height};
        row_height = '0;
      end
      if (({7'd0, cursor_y} + r.height) > SIZE_MAX) begin
        if ({1'b0, fill_layer} + 9'd1 >= {1'b0, layer_count}) begin
          res.status = gasa_pkg::ST_FULL;
          rejected = 1'b1;
        end else begin
          cursor_x = '0;
          cursor_y = '0;
          row_height = '0;
          fill_layer = fill_layer + 8'd1;
        end
      end
      if (!rejected) begin
        slot.s = cursor_x;
        slot.t = cursor_y[7:0];
        slot.layer = fill_layer;
        slot.w = r.width[7:0];
        slot.h = r.height[7:0];
        slot.bx = r.bear_x;
        slot.by = r.bear_y;
        cursor_x = cursor_x + r.width[7:0];
        if (r.height[7:0] > row_height) row_height = r.height[7:0];
        if (glyph_present[r.code]) begin
          res.status = gasa_pkg::ST_DUPLICATE;
        end else begin
          glyph_present[r.code] = 1'b1;
          glyph_table[r.code] = slot;
          res.entry = slot;
        end
      end
    end
    if (int'(fill_layer) > deepest_layer) deepest_layer = int'(fill_layer);
    res.current_layer = fill_layer;
    return res;
  endfunction

  function automatic glyph_req_t mk(gasa_pkg::req_type_t k, int code, int w, int h,
                                    int bx, int by);
    glyph_req_t r;
    r.kind = k;
    r.code = code[15:0];
    r.width = w[15:0];
    r.height = h[15:0];
    r.bear_x = bx[15:0];
    r.bear_y = by[15:0];
    return r;
  endfunction

  function automatic glyph_req_t random_request();
    glyph_req_t r;
    int         p;
    p = $urandom_range(0, 99);
    r.kind = gasa_pkg::REQ_INSERT;
    r.code = 16'($urandom_range(0, TABLE_ENTRIES - 1));
    r.width = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 48));
    r.height = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 48));
    r.bear_x = 16'($urandom);
    r.bear_y = 16'($urandom);
    if (p < 2) begin
      r.kind = gasa_pkg::REQ_CLEAR;
      r.code = 16'($urandom);
    end else if (p < 8) begin
      r.kind = gasa_pkg::req_type_t'($urandom_range(0, 2));
      r.code = 16'($urandom_range(TABLE_ENTRIES, 65535));
    end else if (p < 14) begin
      if ($urandom_range(0, 1)) r.width = 16'($urandom_range(256, 65535));
      else r.height = 16'($urandom_range(256, 65535));
    end else if (p < 20) begin
      // noise: every field fully random
      r.kind = gasa_pkg::req_type_t'($urandom_range(0, 3));
      r.code = 16'($urandom);
      r.width = 16'($urandom);
      r.height = 16'($urandom);
    end else if (p < 35) begin
      r.kind = gasa_pkg::REQ_LOOKUP;
    end else if (p < 42) begin
      r.kind = gasa_pkg::REQ_BLANK;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic send_request(input glyph_req_t r);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_ch.req_type <= r.kind;
    req_ch.char_code <= r.code;
    req_ch.rect_width <= r.width;
    req_ch.rect_height <= r.height;
    req_ch.offset_x <= r.bear_x;
    req_ch.offset_y <= r.bear_y;
    req_ch.valid <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_q.push_back(place_glyph(r));
    requests_sent++;
    kind_count[r.kind]++;
    burst_left--;
  endtask

  // Drop valid, drain every result, then cover a clearing pass before going on.
  task automatic settle_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_layer_count(input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    layer_count = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    gasa_pkg::pk_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending", rsp_ch.status, '0);
      end else begin
        want = expected_q.pop_front();
        status_seen[want.status]++;
        if (rsp_ch.status !== want.status) report_mismatch("status", rsp_ch.status, want.status);
        if (rsp_ch.tex_s !== want.entry.s) report_mismatch("tex_s", rsp_ch.tex_s, want.entry.s);
        if (rsp_ch.tex_t !== want.entry.t) report_mismatch("tex_t", rsp_ch.tex_t, want.entry.t);
        if (rsp_ch.tex_layer !== want.entry.layer)
          report_mismatch("tex_layer", rsp_ch.tex_layer, want.entry.layer);
        if (rsp_ch.out_width !== want.entry.w)
          report_mismatch("out_width", rsp_ch.out_width, want.entry.w);
        if (rsp_ch.out_height !== want.entry.h)
          report_mismatch("out_height", rsp_ch.out_height, want.entry.h);
        if (rsp_ch.out_bearing_x !== want.entry.bx)
          report_mismatch("out_bearing_x", rsp_ch.out_bearing_x, want.entry.bx);
        if (rsp_ch.out_bearing_y !== want.entry.by)
          report_mismatch("out_bearing_y", rsp_ch.out_bearing_y, want.entry.by);
        if (rsp_ch.current_layer !== want.current_layer)
          report_mismatch("current_layer", rsp_ch.current_layer, want.current_layer);
      end
    end
  end

  // Response sink: long hold when asked, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (sink_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
        2: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
        default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Reset value of the layer count is zero: no layer beyond the first.
  task automatic test_reset_defaults();
    send_request(mk(gasa_pkg::REQ_LOOKUP, 0, 0, 0, 0, 0));
    send_request(mk(gasa_pkg::REQ_INSERT, 0, 0, 0, -32768, 32767));
    send_request(mk(gasa_pkg::REQ_INSERT, 0, 10, 10, 1, 1));
    send_request(mk(gasa_pkg::REQ_LOOKUP, 0, 0, 0, 0, 0));
    send_request(mk(gasa_pkg::REQ_INSERT, 1, 256, 5, 0, 0));
    send_request(mk(gasa_pkg::REQ_INSERT, 2, 5, 65535, 0, 0));
    send_request(mk(gasa_pkg::REQ_INSERT, 255, 245, 255, 32767, -32768));
    // wrap onto the last texel row with a zero-height glyph
    send_request(mk(gasa_pkg::REQ_INSERT, 3, 1, 0, 7, 7));
    send_request(mk(gasa_pkg::REQ_INSERT, 4, 1, 1, 0, 0));
    send_request(mk(gasa_pkg::REQ_BLANK, 255, 9, 9, 9, 9));
    send_request(mk(gasa_pkg::REQ_LOOKUP, 255, 0, 0, 0, 0));
    send_request(mk(gasa_pkg::REQ_INSERT, 256, 1, 1, 0, 0));
    send_request(mk(gasa_pkg::REQ_BLANK, 65535, 0, 0, 0, 0));
    send_request(mk(gasa_pkg::REQ_LOOKUP, 256, 0, 0, 0, 0));
    send_request(mk(gasa_pkg::REQ_INSERT, 65535, 65535, 65535, -1, -1));
    send_request(mk(gasa_pkg::REQ_CLEAR, 65535, 65535, 65535, -1, -1));
    send_request(mk(gasa_pkg::REQ_LOOKUP, 0, 0, 0, 0, 0));
    settle_idle();
  endtask

  task automatic test_layer_advance();
    write_layer_count(8'd2);
    send_request(mk(gasa_pkg::REQ_INSERT, 10, 255, 200, 3, -3));
    send_request(mk(gasa_pkg::REQ_INSERT, 11, 100, 100, -5, 5));
    send_request(mk(gasa_pkg::REQ_INSERT, 12, 200, 200, 0, 0));
    settle_idle();
    write_layer_count(8'd255);
    send_request(mk(gasa_pkg::REQ_INSERT, 12, 200, 200, 12, 12));
    send_request(mk(gasa_pkg::REQ_INSERT, 13, 255, 255, 13, 13));
    send_request(mk(gasa_pkg::REQ_LOOKUP, 11, 0, 0, 0, 0));
    settle_idle();
  endtask

  // Hold the response side while requests keep coming so the input stalls.
  task automatic test_output_stall();
    hold_request = 400;
    burst_left = 64;
    repeat (60) send_request(random_request());
    settle_idle();
  endtask

  task automatic test_random_traffic();
    int          layer_plan[6] = '{1, 255, 0, 0, 4, 255};
    logic [7:0]  setting;
    for (int p = 0; p < 6; p++) begin
      setting = (p == 3) ? 8'($urandom_range(2, 254)) : 8'(layer_plan[p]);
      write_layer_count(setting);
      no_gaps = (p == 2);
      repeat (240) send_request(random_request());
      settle_idle();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.char_code = '0;
    req_ch.rect_width = '0;
    req_ch.rect_height = '0;
    req_ch.offset_x = '0;
    req_ch.offset_y = '0;
    rsp_ch.ready = 1'b0;
    layer_count = '0;
    cursor_x = '0;
    cursor_y = '0;
    row_height = '0;
    fill_layer = '0;
    foreach (glyph_present[i]) glyph_present[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_layer_advance();
    test_output_stall();
    test_random_traffic();

    repeat (10) @(posedge clk);
    $display("Sent %0d requests (%0d insert, %0d blank, %0d lookup, %0d clear)",
             requests_sent, kind_count[gasa_pkg::REQ_INSERT], kind_count[gasa_pkg::REQ_BLANK],
             kind_count[gasa_pkg::REQ_LOOKUP], kind_count[gasa_pkg::REQ_CLEAR]);
    $display("%0d results checked; ok/large/full/dup/missing/range %0d/%0d/%0d/%0d/%0d/%0d",
             results_checked, status_seen[gasa_pkg::ST_OK], status_seen[gasa_pkg::ST_TOO_LARGE],
             status_seen[gasa_pkg::ST_FULL], status_seen[gasa_pkg::ST_DUPLICATE],
             status_seen[gasa_pkg::ST_NOT_FOUND], status_seen[gasa_pkg::ST_RANGE]);
    $display("Deepest layer reached %0d", deepest_layer);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, expected_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/gasa_pkg.sv
hdl/gasa_if.sv
hdl/gasa_table.sv
hdl/gasa_packer.sv
hdl/glyph_atlas_shelf_allocator_core.sv
sim/glyph_atlas_shelf_allocator_core_tb.sv
